[src/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg: shared types and helpers for the Mandelbrot escape color core
// Item formats, the record that passes from one iteration cell to the next,
// fixed-point constants and small arithmetic functions.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int unsigned COUNT_W     = 15;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned NUM_CELLS   = 2;
  localparam int unsigned WIDE_W      = 38;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 15'd255;

  // |z|^2 bound of 4.0 in Q8.56, with one extra bit for the sum.
  localparam logic [64:0] ESCAPE_BOUND = 65'd1 << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] escape_count;
    logic [COLOR_W-1:0] pixel_color;
  } out_item_t;

  // One point as it travels around the ring of cells.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } ring_t;

  function automatic logic [31:0] magnitude(input logic signed [31:0] v);
    magnitude = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Clamp a wide signed sum into the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1);
    if (fits) begin
      sat32 = v[31:0];
    end else if (v[WIDE_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  // Each of the eight low count bits is doubled into a pair of equal bits.
  function automatic logic [COLOR_W-1:0] double_bits(input logic [7:0] cnt);
    logic [COLOR_W-1:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c[2*k]   = cnt[k];
      c[2*k+1] = cnt[k];
    end
    double_bits = c;
  endfunction

endpackage

[src/mec_cell.sv]
// ----------------------------------------------------------------------------
// mec_cell: one iteration cell of the ring
// Stage one registers the three products of z; stage two runs the escape
// and limit test and forms the next z, handing the point to the next cell.
// ----------------------------------------------------------------------------
module mec_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mec_pkg::COUNT_W-1:0]   limit,
  input  mec_pkg::ring_t                cell_in,
  output mec_pkg::ring_t                cell_out
);

  logic                          a_valid_r;
  logic                          a_done_r;
  logic [mec_pkg::COUNT_W-1:0]   a_count_r;
  logic [63:0]                   a_xx_r;
  logic [63:0]                   a_yy_r;
  logic signed [63:0]            a_xy_r;
  logic signed [31:0]            a_cr_r;
  logic signed [31:0]            a_ci_r;

  logic [31:0]                   mag_x;
  logic [31:0]                   mag_y;
  logic [63:0]                   xx_nxt;
  logic [63:0]                   yy_nxt;
  logic signed [63:0]            xy_nxt;

  logic                          b_valid_r;
  logic                          b_done_r;
  logic [mec_pkg::COUNT_W-1:0]   b_count_r;
  logic signed [31:0]            b_x_r;
  logic signed [31:0]            b_y_r;
  logic signed [31:0]            b_cr_r;
  logic signed [31:0]            b_ci_r;

  logic [64:0]                   mag_sum;
  logic                          stop;
  logic signed [mec_pkg::WIDE_W-1:0] x_wide;
  logic signed [mec_pkg::WIDE_W-1:0] y_wide;

  assign mag_x  = mec_pkg::magnitude(cell_in.x);
  assign mag_y  = mec_pkg::magnitude(cell_in.y);
  assign xx_nxt = {32'd0, mag_x} * {32'd0, mag_x};
  assign yy_nxt = {32'd0, mag_y} * {32'd0, mag_y};
  assign xy_nxt = 64'(cell_in.x) * 64'(cell_in.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= cell_in.valid;
      b_valid_r <= a_valid_r;
    end
  end

  // Payload of both stages carries no reset.
  always_ff @(posedge clk) begin
    a_done_r  <= cell_in.done;
    a_count_r <= cell_in.count;
    a_xx_r    <= xx_nxt;
    a_yy_r    <= yy_nxt;
    a_xy_r    <= xy_nxt;
    a_cr_r    <= cell_in.cr;
    a_ci_r    <= cell_in.ci;

    b_done_r  <= stop;
    b_count_r <= stop ? a_count_r : a_count_r + 15'd1;
    b_x_r     <= mec_pkg::sat32(x_wide);
    b_y_r     <= mec_pkg::sat32(y_wide);
    b_cr_r    <= a_cr_r;
    b_ci_r    <= a_ci_r;
  end

  // The count test comes first, then the escape test on the current z.
  // Once a point is done its count holds; its z is no longer looked at.
  assign mag_sum = {1'b0, a_xx_r} + {1'b0, a_yy_r};
  assign stop    = a_done_r || (a_count_r >= limit) || (mag_sum > mec_pkg::ESCAPE_BOUND);

  // x' = floor(x^2) - floor(y^2) + cr; y' = floor(2xy) + ci, all Q4.28.
  assign x_wide = $signed({2'b00, a_xx_r[63:mec_pkg::FRAC_BITS]})
                - $signed({2'b00, a_yy_r[63:mec_pkg::FRAC_BITS]})
                + mec_pkg::WIDE_W'(a_cr_r);
  assign y_wide = $signed({a_xy_r[63], a_xy_r[63:mec_pkg::FRAC_BITS-1]})
                + mec_pkg::WIDE_W'(a_ci_r);

  always_comb begin
    cell_out       = '0;
    cell_out.valid = b_valid_r;
    cell_out.done  = b_done_r;
    cell_out.count = b_count_r;
    cell_out.x     = b_x_r;
    cell_out.y     = b_y_r;
    cell_out.cr    = b_cr_r;
    cell_out.ci    = b_ci_r;
  end

endmodule

[src/mandelbrot_escape_color_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_core: escape count and 16-bit color of one point
// A point goes round the ring of cells, one iteration per cell, until it is
// done; each cell registers the products of z, then the update, per pass.
// Throughput: one point in the ring of cells at a time; in_stall is high from
// acceptance until the point leaves the ring, so the ring latency sets the rate.
// Reset (synchronous, rst_n low) empties the ring and sets the limit to 255.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color_core #(
  parameter int unsigned CELLS = mec_pkg::NUM_CELLS
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  mec_pkg::in_item_t           in_item,

  output logic                        out_valid,
  input  logic                        out_stall,
  output mec_pkg::out_item_t          out_item,

  input  logic                        cfg_wr_en,
  input  logic [mec_pkg::COUNT_W-1:0] cfg_wr_data
);

  logic [mec_pkg::COUNT_W-1:0] limit_r;
  logic [mec_pkg::COUNT_W-1:0] limit_nxt;
  logic                        busy_r;
  logic                        busy_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  mec_pkg::out_item_t          out_item_r;
  mec_pkg::out_item_t          out_item_nxt;

  mec_pkg::ring_t              ring [CELLS+1];
  mec_pkg::ring_t              feed;
  mec_pkg::ring_t              tail;

  logic                        in_accept;
  logic                        exit_go;

  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  assign tail      = ring[CELLS];

  // A finished point that cannot leave yet simply goes around once more.
  assign exit_go = tail.valid && tail.done && (!out_valid_r || !out_stall);

  always_comb begin
    feed = tail;
    if (in_accept) begin
      feed       = '0;
      feed.valid = 1'b1;
      feed.cr    = in_item.c_real;
      feed.ci    = in_item.c_imag;
    end else if (exit_go) begin
      feed.valid = 1'b0;
    end
  end

  assign ring[0] = feed;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    mec_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .limit    (limit_r),
      .cell_in  (ring[i]),
      .cell_out (ring[i+1])
    );
  end

  always_comb begin
    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;

    busy_nxt = busy_r;
    if (in_accept) begin
      busy_nxt = 1'b1;
    end else if (exit_go) begin
      busy_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (exit_go) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.escape_count = tail.count;
      out_item_nxt.pixel_color  = (tail.count < limit_r)
                                ? mec_pkg::double_bits(tail.count[7:0])
                                : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= mec_pkg::LIMIT_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
